// ----- sv/bsp_pkg.sv -----
`default_nettype none

package bsp_pkg;

    // Width of the transaction, input, output and script length counters.
    localparam int CNT_W = 32;

    // Largest count or length that the counters hold; larger varints saturate here.
    localparam logic [63:0] COUNT_MAX = 64'({CNT_W{1'b1}});

    // Varint prefixes for two, four and eight following bytes.
    localparam logic [7:0] VARINT_P16 = 8'd253;
    localparam logic [7:0] VARINT_P32 = 8'd254;
    localparam logic [7:0] VARINT_P64 = 8'd255;

    // Field kinds, in block-file order.
    localparam logic [4:0] K_MAGIC   = 5'd0;
    localparam logic [4:0] K_SIZE    = 5'd1;
    localparam logic [4:0] K_VERSION = 5'd2;
    localparam logic [4:0] K_PREVBLK = 5'd3;
    localparam logic [4:0] K_MERKLE  = 5'd4;
    localparam logic [4:0] K_TIME    = 5'd5;
    localparam logic [4:0] K_BITS    = 5'd6;
    localparam logic [4:0] K_NONCE   = 5'd7;
    localparam logic [4:0] K_TXCNT   = 5'd8;
    localparam logic [4:0] K_TXVER   = 5'd9;
    localparam logic [4:0] K_INCNT   = 5'd10;
    localparam logic [4:0] K_PREVTX  = 5'd11;
    localparam logic [4:0] K_OUTIDX  = 5'd12;
    localparam logic [4:0] K_ISLEN   = 5'd13;
    localparam logic [4:0] K_ISCRIPT = 5'd14;
    localparam logic [4:0] K_SEQ     = 5'd15;
    localparam logic [4:0] K_OUTCNT  = 5'd16;
    localparam logic [4:0] K_VALUE   = 5'd17;
    localparam logic [4:0] K_OSLEN   = 5'd18;
    localparam logic [4:0] K_OSCRIPT = 5'd19;
    localparam logic [4:0] K_LOCK    = 5'd20;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [4:0]       phase;
        logic             vphase;
        logic [CNT_W-1:0] left;
        logic [31:0]      pos;
        logic [63:0]      acc;
        logic [CNT_W-1:0] tx_left;
        logic [31:0]      tx_idx;
        logic [CNT_W-1:0] ent_left;
        logic [31:0]      ent_idx;
    } parse_state_t;

    // Tags attached to one byte.
    typedef struct packed {
        logic [4:0]  field_kind;
        logic [7:0]  byte_echo;
        logic [31:0] byte_in_field;
        logic        field_end;
        logic [63:0] field_value;
        logic [31:0] tx_number;
        logic [31:0] entry_number;
        logic        block_end;
        logic        count_overflow;
    } parse_result_t;

    // State at reset and at the start of every block.
    localparam parse_state_t START_STATE = '{
        phase:    K_MAGIC,
        vphase:   1'b0,
        left:     CNT_W'(4),
        pos:      32'd0,
        acc:      64'd0,
        tx_left:  '0,
        tx_idx:   32'd0,
        ent_left: '0,
        ent_idx:  32'd0
    };

    function automatic logic is_varint(logic [4:0] kind);
        return kind inside {K_TXCNT, K_INCNT, K_ISLEN, K_OUTCNT, K_OSLEN};
    endfunction

    function automatic logic is_opaque(logic [4:0] kind);
        return kind inside {K_PREVBLK, K_MERKLE, K_PREVTX, K_ISCRIPT, K_OSCRIPT};
    endfunction

endpackage

`default_nettype wire

// ----- sv/bsp_step.sv -----
`default_nettype none

module bsp_step
    import bsp_pkg::*;
(
    input  wire parse_state_t  st,
    input  wire logic [7:0]    data_byte,
    output parse_state_t       nxt,
    output parse_result_t      res
);

    logic [4:0]       kind;
    logic             varint;
    logic             opaque;
    logic [31:0]      idx;
    logic             lane_ok;
    logic [63:0]      acc_upd;
    logic             end_flag;
    logic [63:0]      value;
    logic             sat_hi;
    logic [CNT_W-1:0] cnt;
    logic             ovf;
    logic             bend;
    parse_state_t     s1;

    // Starts a new field of the given kind and length.
    function automatic parse_state_t begin_field(parse_state_t s, logic [4:0] k,
                                                 logic [CNT_W-1:0] len);
        parse_state_t r;
        r        = s;
        r.phase  = k;
        r.left   = len;
        r.pos    = 32'd0;
        r.acc    = 64'd0;
        r.vphase = 1'b0;
        return r;
    endfunction

    // Steps to the next output, or to the lock time after the last one.
    function automatic parse_state_t next_output(parse_state_t s);
        parse_state_t r;
        r          = s;
        r.ent_left = s.ent_left - CNT_W'(1);
        if (s.ent_left == CNT_W'(1)) begin
            r.ent_idx = 32'd0;
            r         = begin_field(r, K_LOCK, CNT_W'(4));
        end else begin
            r.ent_idx = s.ent_idx + 32'd1;
            r         = begin_field(r, K_VALUE, CNT_W'(8));
        end
        return r;
    endfunction

    // Byte lane merge for little-endian numeric fields.
    always_comb begin
        kind    = (st.phase > K_LOCK) ? K_LOCK : st.phase;
        varint  = is_varint(kind);
        opaque  = is_opaque(kind);
        idx     = st.pos - {31'd0, varint};
        lane_ok = !opaque && (idx[31:3] == 29'd0);
        for (int i = 0; i < 8; i++) begin
            acc_upd[8*i +: 8] = (lane_ok && idx[2:0] == 3'(i)) ? data_byte
                                                                : st.acc[8*i +: 8];
        end
    end

    // Byte consumption, field transitions and the result tags.
    always_comb begin
        s1       = st;
        s1.phase = kind;
        end_flag = 1'b0;

        if (varint && !st.vphase) begin
            // First byte of a varint: either the value itself or a length prefix.
            if (data_byte < VARINT_P16) begin
                s1.acc   = {56'd0, data_byte};
                end_flag = 1'b1;
            end else begin
                s1.vphase = 1'b1;
                s1.acc    = 64'd0;
                case (data_byte)
                    VARINT_P16: s1.left = CNT_W'(2);
                    VARINT_P32: s1.left = CNT_W'(4);
                    default:    s1.left = CNT_W'(8);
                endcase
            end
        end else begin
            s1.acc = acc_upd;
            if (st.left <= CNT_W'(1)) begin
                s1.left  = '0;
                end_flag = 1'b1;
            end else begin
                s1.left = st.left - CNT_W'(1);
            end
        end

        value  = (end_flag && !opaque) ? s1.acc : 64'd0;
        sat_hi = value > COUNT_MAX;
        cnt    = sat_hi ? COUNT_MAX[CNT_W-1:0] : value[CNT_W-1:0];
        ovf    = 1'b0;
        bend   = 1'b0;
        nxt    = s1;

        if (!end_flag) begin
            nxt.pos = st.pos + 32'd1;
        end else begin
            unique case (kind)
                K_MAGIC:   nxt = begin_field(s1, K_SIZE, CNT_W'(4));
                K_SIZE:    nxt = begin_field(s1, K_VERSION, CNT_W'(4));
                K_VERSION: nxt = begin_field(s1, K_PREVBLK, CNT_W'(32));
                K_PREVBLK: nxt = begin_field(s1, K_MERKLE, CNT_W'(32));
                K_MERKLE:  nxt = begin_field(s1, K_TIME, CNT_W'(4));
                K_TIME:    nxt = begin_field(s1, K_BITS, CNT_W'(4));
                K_BITS:    nxt = begin_field(s1, K_NONCE, CNT_W'(4));
                K_NONCE:   nxt = begin_field(s1, K_TXCNT, CNT_W'(1));
                K_TXCNT: begin
                    ovf = sat_hi;
                    if (cnt == '0) begin
                        nxt  = START_STATE;
                        bend = 1'b1;
                    end else begin
                        s1.tx_left = cnt;
                        s1.tx_idx  = 32'd0;
                        s1.ent_idx = 32'd0;
                        nxt        = begin_field(s1, K_TXVER, CNT_W'(4));
                    end
                end
                K_TXVER:   nxt = begin_field(s1, K_INCNT, CNT_W'(1));
                K_INCNT: begin
                    ovf         = sat_hi;
                    s1.ent_idx  = 32'd0;
                    s1.ent_left = cnt;
                    if (cnt == '0) begin
                        nxt = begin_field(s1, K_OUTCNT, CNT_W'(1));
                    end else begin
                        nxt = begin_field(s1, K_PREVTX, CNT_W'(32));
                    end
                end
                K_PREVTX:  nxt = begin_field(s1, K_OUTIDX, CNT_W'(4));
                K_OUTIDX:  nxt = begin_field(s1, K_ISLEN, CNT_W'(1));
                K_ISLEN: begin
                    ovf = sat_hi;
                    if (cnt == '0) begin
                        nxt = begin_field(s1, K_SEQ, CNT_W'(4));
                    end else begin
                        nxt = begin_field(s1, K_ISCRIPT, cnt);
                    end
                end
                K_ISCRIPT: nxt = begin_field(s1, K_SEQ, CNT_W'(4));
                K_SEQ: begin
                    s1.ent_left = st.ent_left - CNT_W'(1);
                    if (st.ent_left == CNT_W'(1)) begin
                        s1.ent_idx = 32'd0;
                        nxt        = begin_field(s1, K_OUTCNT, CNT_W'(1));
                    end else begin
                        s1.ent_idx = st.ent_idx + 32'd1;
                        nxt        = begin_field(s1, K_PREVTX, CNT_W'(32));
                    end
                end
                K_OUTCNT: begin
                    ovf         = sat_hi;
                    s1.ent_idx  = 32'd0;
                    s1.ent_left = cnt;
                    if (cnt == '0) begin
                        nxt = begin_field(s1, K_LOCK, CNT_W'(4));
                    end else begin
                        nxt = begin_field(s1, K_VALUE, CNT_W'(8));
                    end
                end
                K_VALUE:   nxt = begin_field(s1, K_OSLEN, CNT_W'(1));
                K_OSLEN: begin
                    ovf = sat_hi;
                    if (cnt == '0) begin
                        nxt = next_output(s1);
                    end else begin
                        nxt = begin_field(s1, K_OSCRIPT, cnt);
                    end
                end
                K_OSCRIPT: nxt = next_output(s1);
                default: begin
                    // Lock time closes the transaction.
                    s1.tx_left = st.tx_left - CNT_W'(1);
                    if (st.tx_left == CNT_W'(1)) begin
                        nxt  = START_STATE;
                        bend = 1'b1;
                    end else begin
                        s1.tx_idx  = st.tx_idx + 32'd1;
                        s1.ent_idx = 32'd0;
                        nxt        = begin_field(s1, K_TXVER, CNT_W'(4));
                    end
                end
            endcase
        end

        res.field_kind     = kind;
        res.byte_echo      = data_byte;
        res.byte_in_field  = st.pos;
        res.field_end      = end_flag;
        res.field_value    = value;
        res.tx_number      = st.tx_idx;
        res.entry_number   = st.ent_idx;
        res.block_end      = bend;
        res.count_overflow = ovf;
    end

endmodule

`default_nettype wire

// ----- sv/blockchain_block_stream_parser_unit.sv -----
`default_nettype none

// Channel   Direction  Ports                                  Content
// s_        in         s_valid, s_ready, s_data_byte          one raw byte of the block file
// m_        out        m_valid, m_ready, m_field_kind ...     that byte with its field tags
//
// One byte per clock is sustained while m_ready stays high; an accepted byte passes through
// the input register, then the result register written by the field decoder, to m_valid.
// The parse state advances in the same cycle the result is registered, so the
// field decoder is the single step that sets the rate.
// Reset (aresetn low, synchronous) empties both registers and restarts at the magic field.
// When m_ready is low the result holds and one more byte can wait in the input register.

module blockchain_block_stream_parser_unit
    import bsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_field_kind,
    output logic [7:0]       m_byte_echo,
    output logic [31:0]      m_byte_in_field,
    output logic             m_field_end,
    output logic [63:0]      m_field_value,
    output logic [31:0]      m_tx_number,
    output logic [31:0]      m_entry_number,
    output logic             m_block_end,
    output logic             m_count_overflow
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    parse_result_t result_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_next;
    logic          load_ok;
    logic          fire;

    // The result register can take a new transaction when empty or being drained.
    assign load_ok = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && load_ok;
    assign s_ready = !in_valid_reg || load_ok;

    bsp_step u_step (
        .st        (state_reg),
        .data_byte (in_byte_reg),
        .nxt       (state_next),
        .res       (result_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Parse state advances once per byte handed to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= START_STATE;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_field_kind     = result_reg.field_kind;
    assign m_byte_echo      = result_reg.byte_echo;
    assign m_byte_in_field  = result_reg.byte_in_field;
    assign m_field_end      = result_reg.field_end;
    assign m_field_value    = result_reg.field_value;
    assign m_tx_number      = result_reg.tx_number;
    assign m_entry_number   = result_reg.entry_number;
    assign m_block_end      = result_reg.block_end;
    assign m_count_overflow = result_reg.count_overflow;

endmodule

`default_nettype wire

// ----- sv/bsp_checker.sv -----
`default_nettype none

module bsp_checker
    import bsp_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [4:0]  m_field_kind,
    input wire logic [7:0]  m_byte_echo,
    input wire logic [31:0] m_byte_in_field,
    input wire logic        m_field_end,
    input wire logic [63:0] m_field_value,
    input wire logic [31:0] m_tx_number,
    input wire logic [31:0] m_entry_number,
    input wire logic        m_block_end,
    input wire logic        m_count_overflow
);

    // A stalled result transaction stays valid and keeps its kind, byte, position, value and numbers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_kind)
                                && $stable(m_byte_echo) && $stable(m_byte_in_field)
                                && $stable(m_field_value) && $stable(m_tx_number)
                                && $stable(m_entry_number))
        else $error("stalled result changed");

    // Values appear only on the closing byte of a field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_field_end |-> m_field_value == 64'd0)
        else $error("field value outside field end");

    // A block ends only where a transaction count or a lock time closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_end |-> m_field_end
                                   && (m_field_kind == K_TXCNT || m_field_kind == K_LOCK))
        else $error("block end on wrong byte");

    // Saturation is only reported at the end of a count or length varint.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_count_overflow |-> m_field_end
            && (m_field_kind == K_TXCNT || m_field_kind == K_INCNT
                || m_field_kind == K_ISLEN || m_field_kind == K_OUTCNT
                || m_field_kind == K_OSLEN))
        else $error("overflow flag on wrong field");

    // After a block end the next byte starts the magic field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_block_end ##1 m_valid |-> m_field_kind == K_MAGIC
                                                         && m_byte_in_field == 32'd0)
        else $error("next block does not start at magic");

endmodule

bind blockchain_block_stream_parser_unit bsp_checker u_bsp_checker (.*);

`default_nettype wire
